### rtl/suspension_travel_scaler_macros.svh
// assertion macros for the suspension travel scaler
`ifndef SUSPENSION_TRAVEL_SCALER_MACROS_SVH
`define SUSPENSION_TRAVEL_SCALER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define STS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define STS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define STS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/sts_pkg.sv
// shared types and constants of the suspension travel scaler
`timescale 1ns / 1ps

package sts_pkg;

	localparam int ENDPOINT_BITS = 12;
	localparam int STROKE_BITS   = 14;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;

	localparam logic [ENDPOINT_BITS-1:0] DEFAULT_EXTENDED_RST   = 12'd1100;
	localparam logic [ENDPOINT_BITS-1:0] DEFAULT_COMPRESSED_RST = 12'd1950;
	localparam logic [STROKE_BITS-1:0]   STROKE_LENGTH_RST      = 14'd1000;

	// register index, byte address 4*index
	typedef enum logic [2:0] {
		REG_DEFAULT_EXTENDED   = 3'd0,
		REG_DEFAULT_COMPRESSED = 3'd1,
		REG_CALIB_EXTENDED     = 3'd2,
		REG_CALIB_COMPRESSED   = 3'd3,
		REG_EXTENDED_VALID     = 3'd4,
		REG_COMPRESSED_VALID   = 3'd5,
		REG_STROKE_LENGTH      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [ENDPOINT_BITS-1:0] default_extended;
		logic [ENDPOINT_BITS-1:0] default_compressed;
		logic [ENDPOINT_BITS-1:0] calib_extended;
		logic [ENDPOINT_BITS-1:0] calib_compressed;
		logic                     extended_valid;
		logic                     compressed_valid;
		logic [STROKE_BITS-1:0]   stroke_length;
	} cfg_t;

endpackage

### rtl/sts_front.sv
// front end: accepts samples, picks endpoints, clamps and forms distance and span
`timescale 1ns / 1ps

module sts_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        raw_sample,
	input  sts_pkg::cfg_t                 cfg,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [2*SAMPLE_BITS:0]        q_wr_data
);

	localparam int WW = (sts_pkg::ENDPOINT_BITS > SAMPLE_BITS) ?
		sts_pkg::ENDPOINT_BITS : SAMPLE_BITS;

	logic [WW-1:0]          ext_w, comp_w;
	logic [SAMPLE_BITS-1:0] ext, comp, lo, hi, clamped, distance, span;
	logic                   ascending, zero;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// endpoints are taken modulo the sample range
	assign ext_w = cfg.extended_valid ? WW'(cfg.calib_extended) : WW'(cfg.default_extended);
	assign comp_w = cfg.compressed_valid ? WW'(cfg.calib_compressed) :
		WW'(cfg.default_compressed);
	assign ext  = ext_w[SAMPLE_BITS-1:0];
	assign comp = comp_w[SAMPLE_BITS-1:0];

	assign ascending = ext < comp;
	assign lo        = ascending ? ext : comp;
	assign hi        = ascending ? comp : ext;
	assign zero      = ext == comp;

	always_comb begin
		priority if (raw_sample > hi) begin
			clamped = hi;
		end else if (raw_sample < lo) begin
			clamped = lo;
		end else begin
			clamped = raw_sample;
		end
	end

	// distance from the extended end, same sign as the span after clamping
	assign distance = ascending ? clamped - ext : ext - clamped;
	assign span     = hi - lo;

	assign q_wr_data = {zero, span, distance};

endmodule

### rtl/sts_queue.sv
// small flop-based fifo between front and back
`timescale 1ns / 1ps

module sts_queue #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full    = count_q == CNT_BITS'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/sts_back.sv
// back end: multiply by stroke, pipelined restoring divide, output register
`timescale 1ns / 1ps

module sts_back #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic [2*SAMPLE_BITS:0]            q_rd_data,
	output logic                              q_pop,
	input  logic [sts_pkg::STROKE_BITS-1:0]   stroke_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sts_pkg::STROKE_BITS-1:0]   travel
);

	localparam int QW   = sts_pkg::STROKE_BITS;
	localparam int PW   = SAMPLE_BITS + QW;
	localparam int NSTG = QW / 2;

	logic                   stall;
	logic [SAMPLE_BITS-1:0] distance, span;
	logic                   zero;
	logic [PW-1:0]          prod;

	// multiply stage
	logic                   vld_s1;
	logic [PW-1:0]          prod_s1;
	logic [SAMPLE_BITS-1:0] span_s1;
	logic                   zero_s1;

	// divider stages, entry k is pipeline stage s2+k
	logic                   div_vld_s2  [NSTG];
	logic [PW-1:0]          div_rem_s2  [NSTG];
	logic [QW-1:0]          div_quo_s2  [NSTG];
	logic [SAMPLE_BITS-1:0] div_span_s2 [NSTG];
	logic                   div_zero_s2 [NSTG];

	logic                   out_valid_q;
	logic [QW-1:0]          travel_q;

	assign stall = out_valid_q && !out_ready;
	assign q_pop = !stall && !q_empty;

	assign distance = q_rd_data[SAMPLE_BITS-1:0];
	assign span     = q_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign zero     = q_rd_data[2*SAMPLE_BITS];
	assign prod     = PW'(distance) * PW'(stroke_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			prod_s1 <= prod;
			span_s1 <= span;
			zero_s1 <= zero;
		end
	end

	// two quotient bits per stage; distance <= span keeps the quotient within the stroke
	for (genvar k = 0; k < NSTG; k++) begin : g_div
		logic                   in_vld, in_zero;
		logic [PW-1:0]          in_rem, rem_nxt;
		logic [QW-1:0]          in_quo, quo_nxt;
		logic [SAMPLE_BITS-1:0] in_span;

		if (k == 0) begin : g_first
			assign in_vld  = vld_s1;
			assign in_rem  = prod_s1;
			assign in_quo  = '0;
			assign in_span = span_s1;
			assign in_zero = zero_s1;
		end else begin : g_next
			assign in_vld  = div_vld_s2[k-1];
			assign in_rem  = div_rem_s2[k-1];
			assign in_quo  = div_quo_s2[k-1];
			assign in_span = div_span_s2[k-1];
			assign in_zero = div_zero_s2[k-1];
		end

		always_comb begin
			int            bitpos;
			logic [PW-1:0] d;
			rem_nxt = in_rem;
			quo_nxt = in_quo;
			for (int j = 0; j < 2; j++) begin
				bitpos = QW - 1 - 2 * k - j;
				d      = PW'(in_span) << bitpos;
				if (rem_nxt >= d) begin
					rem_nxt = rem_nxt - d;
					quo_nxt = quo_nxt | (QW'(1) << bitpos);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s2[k] <= 1'b0;
			end else if (!stall) begin
				div_vld_s2[k] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (!stall) begin
				div_rem_s2[k]  <= rem_nxt;
				div_quo_s2[k]  <= quo_nxt;
				div_span_s2[k] <= in_span;
				div_zero_s2[k] <= in_zero;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= div_vld_s2[NSTG-1];
		end
	end

	// equal endpoints give zero travel
	always_ff @(posedge clk) begin
		if (!stall) begin
			travel_q <= div_zero_s2[NSTG-1] ? '0 : div_quo_s2[NSTG-1];
		end
	end

	assign out_valid = out_valid_q;
	assign travel    = travel_q;

endmodule

### rtl/suspension_travel_scaler.sv
// top level: apb register file, front end, queue and divide back end
`timescale 1ns / 1ps
`include "suspension_travel_scaler_macros.svh"

// channel   | handshake                     | payload
// ----------+-------------------------------+-----------------------------
// input     | in_valid / in_ready           | raw_sample (SAMPLE_BITS)
// output    | out_valid / out_ready         | travel (14)
// config    | psel penable pwrite, pready=1 | paddr (5), pwdata / prdata (32)
//
// one beat per cycle sustained in each direction when the output is taken
// samples pass through the queue entry, the multiply stage, seven divider stages of
// two quotient bits each, then the output register
// arst_n puts the registers at their reset values and empties the pipeline
// an output beat not taken freezes the whole back end; the four-entry queue
// keeps taking input beats until it fills, then in_ready drops

module suspension_travel_scaler #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              raw_sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sts_pkg::STROKE_BITS-1:0]     travel,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sts_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [sts_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [sts_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int QDW = 2 * SAMPLE_BITS + 1;

	sts_pkg::cfg_t     cfg_q;
	sts_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	logic              q_push, q_pop, q_full, q_empty;
	logic [QDW-1:0]    q_wr_data, q_rd_data;

	// register file; a write to the unused eighth slot does nothing
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = sts_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_extended   <= sts_pkg::DEFAULT_EXTENDED_RST;
			cfg_q.default_compressed <= sts_pkg::DEFAULT_COMPRESSED_RST;
			cfg_q.calib_extended     <= '0;
			cfg_q.calib_compressed   <= '0;
			cfg_q.extended_valid     <= 1'b0;
			cfg_q.compressed_valid   <= 1'b0;
			cfg_q.stroke_length      <= sts_pkg::STROKE_LENGTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sts_pkg::REG_DEFAULT_EXTENDED:
					cfg_q.default_extended <= pwdata[sts_pkg::ENDPOINT_BITS-1:0];
				sts_pkg::REG_DEFAULT_COMPRESSED:
					cfg_q.default_compressed <= pwdata[sts_pkg::ENDPOINT_BITS-1:0];
				sts_pkg::REG_CALIB_EXTENDED:
					cfg_q.calib_extended <= pwdata[sts_pkg::ENDPOINT_BITS-1:0];
				sts_pkg::REG_CALIB_COMPRESSED:
					cfg_q.calib_compressed <= pwdata[sts_pkg::ENDPOINT_BITS-1:0];
				sts_pkg::REG_EXTENDED_VALID:
					cfg_q.extended_valid <= pwdata[0];
				sts_pkg::REG_COMPRESSED_VALID:
					cfg_q.compressed_valid <= pwdata[0];
				sts_pkg::REG_STROKE_LENGTH:
					cfg_q.stroke_length <= pwdata[sts_pkg::STROKE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back, zero-extended to the bus
	always_comb begin
		unique case (reg_idx)
			sts_pkg::REG_DEFAULT_EXTENDED:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.default_extended);
			sts_pkg::REG_DEFAULT_COMPRESSED:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.default_compressed);
			sts_pkg::REG_CALIB_EXTENDED:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.calib_extended);
			sts_pkg::REG_CALIB_COMPRESSED:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.calib_compressed);
			sts_pkg::REG_EXTENDED_VALID:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.extended_valid);
			sts_pkg::REG_COMPRESSED_VALID:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.compressed_valid);
			sts_pkg::REG_STROKE_LENGTH:
				prdata = sts_pkg::APB_DATA_BITS'(cfg_q.stroke_length);
			default:
				prdata = '0;
		endcase
	end

	// front end: endpoint select, clamp, distance and span into the queue
	sts_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_sample(raw_sample),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wr_data (q_wr_data)
	);

	// decouples sample intake from output back-pressure
	sts_queue #(
		.WIDTH(QDW),
		.DEPTH(4)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr_data),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back end: dist * stroke / span, one beat per cycle while the output is taken
	sts_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rd_data    (q_rd_data),
		.q_pop        (q_pop),
		.stroke_length(cfg_q.stroke_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.travel       (travel)
	);

	// a held output beat must freeze the back end, so nothing leaves the queue
	`STS_ASSERT_IMPLY(a_stall_no_pop, clk, arst_n, out_valid && !out_ready, !q_pop,
		"queue popped while output stalled")
	// an accepted sample is in the queue on the next cycle
	`STS_ASSERT_NEXT(a_accept_lands, clk, arst_n, in_valid && in_ready, !q_empty,
		"accepted sample missing from queue")
	// the queue never reports full and empty together
	`STS_ASSERT_IMPLY(a_queue_state, clk, arst_n, q_full, !q_empty && !in_ready,
		"queue full flag inconsistent")

endmodule
